/* src/yrpm_pkg.sv */
// Shared constants, types and state codes of the YUV to RGB palette matcher.
`timescale 1ns / 1ps
`default_nettype none
package yrpm_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int IDX_W         = $clog2(PALETTE_DEPTH);
    localparam int COUNT_W       = 9;
    localparam int CHAN_W        = 8;
    localparam int WORD_W        = 4 * CHAN_W;
    localparam int COEF_W        = 18;
    localparam int CHROMA_W      = CHAN_W + 1;
    localparam int PROD_W        = COEF_W + CHROMA_W;
    localparam int SUM_W         = PROD_W + 1;
    localparam int FRAC_W        = 16;
    localparam int CONV_W        = 12;
    localparam int SQ_W          = 2 * CHAN_W;
    localparam int DIST_W        = SQ_W + 2;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    localparam logic [COUNT_W-1:0] LIMIT_MAX = COUNT_W'(PALETTE_DEPTH);

    localparam logic signed [COEF_W-1:0] COEF_R_CR = 18'sd91881;
    localparam logic signed [COEF_W-1:0] COEF_G_CB = 18'sd22554;
    localparam logic signed [COEF_W-1:0] COEF_G_CR = 18'sd46802;
    localparam logic signed [COEF_W-1:0] COEF_B_CB = 18'sd116130;
    localparam logic [CHROMA_W-1:0]      CHROMA_MID = 9'd128;
    localparam logic [CHAN_W-1:0]        CHAN_MAX  = 8'd255;
    localparam logic [DIST_W-1:0]        DIST_INIT = '1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic REG_COUNT = 1'b0;
    localparam logic REG_MONO  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_SEARCH,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             in_ready;
        logic             capture;
        logic             mem_wr;
        logic             mul_en;
        logic             sum_en;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

/* src/yrpm_in_if.sv */
// Input channel: palette loads and pixels.
`timescale 1ns / 1ps
`default_nettype none
interface yrpm_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] entry_index;
    logic [7:0] entry_map_byte;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;

    modport source (
        output valid, cmd, entry_index, entry_map_byte, entry_red, entry_green,
               entry_blue, luma, chroma_blue, chroma_red,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry_index, entry_map_byte, entry_red, entry_green,
               entry_blue, luma, chroma_blue, chroma_red,
        output ready
    );
endinterface
`default_nettype wire

/* src/yrpm_out_if.sv */
// Output channel: one matched word per pixel.
`timescale 1ns / 1ps
`default_nettype none
interface yrpm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] map_byte_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;

    modport source (
        output valid, map_byte_out, red_out, green_out, blue_out,
        input  ready
    );
    modport sink (
        input  valid, map_byte_out, red_out, green_out, blue_out,
        output ready
    );
endinterface
`default_nettype wire

/* src/yuv_to_rgb_palette_matcher.sv */
// Top level of the YUV to RGB nearest-palette matcher.
//
// in_ch carries words of two kinds, chosen by cmd: a palette load writes map
// byte and RGB into entry entry_index; a pixel (luma, chroma_blue, chroma_red)
// is converted to clamped RGB and matched against the first palette_count
// entries for the least squared distance, the first entry winning a tie.
// Each pixel gives one word on out_ch; a load gives none.
// Loads are taken while idle. For a pixel the palette memory is read one
// entry per cycle, over the first min(palette_count, 256) entries, behind a
// two-stage distance pipe. Mono mode or an empty palette skips the search;
// in mono mode the word is the luma as map byte with zero RGB.
// The next word is accepted as soon as the previous pixel has been handed
// to the output register, even while that result still waits on out_ch.
// A stalled receiver holds the output word; a pixel that finishes its
// search then waits until the register is free.
// Reset clears the config registers, valid flags and control state. Palette
// entries are undefined until loaded; load every entry that the count covers.
`timescale 1ns / 1ps
`default_nettype none
module yuv_to_rgb_palette_matcher
    import yrpm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    yrpm_in_if.sink                in_ch,
    yrpm_out_if.source             out_ch
);

    logic [COUNT_W-1:0] palette_count;
    logic               mono_mode;
    ctrl_cmd_t          cmd;
    dp_stat_t           stat;

    yrpm_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .palette_count (palette_count),
        .mono_mode     (mono_mode)
    );

    yrpm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_ch.valid),
        .in_cmd        (in_ch.cmd),
        .palette_count (palette_count),
        .mono_mode     (mono_mode),
        .stat          (stat),
        .cmd           (cmd)
    );

    yrpm_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .mono_mode      (mono_mode),
        .entry_index    (in_ch.entry_index),
        .entry_map_byte (in_ch.entry_map_byte),
        .entry_red      (in_ch.entry_red),
        .entry_green    (in_ch.entry_green),
        .entry_blue     (in_ch.entry_blue),
        .luma           (in_ch.luma),
        .chroma_blue    (in_ch.chroma_blue),
        .chroma_red     (in_ch.chroma_red),
        .out_ready      (out_ch.ready),
        .stat           (stat),
        .out_valid      (out_ch.valid),
        .map_byte_out   (out_ch.map_byte_out),
        .red_out        (out_ch.red_out),
        .green_out      (out_ch.green_out),
        .blue_out       (out_ch.blue_out)
    );

    assign in_ch.ready = cmd.in_ready;

    a_no_accept_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_en || stat.pipe_busy) |-> !cmd.in_ready)
        else $error("input accepted while palette scan in progress");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_ch.valid || out_ch.ready))
        else $error("pending output word overwritten");

    a_mono_zero_rgb: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) && mono_mode |->
            (out_ch.red_out == '0 && out_ch.green_out == '0 && out_ch.blue_out == '0))
        else $error("mono mode result carries color");

endmodule
`default_nettype wire

/* src/yrpm_regs.sv */
// APB configuration registers: palette count and mono mode.
`timescale 1ns / 1ps
`default_nettype none
module yrpm_regs
    import yrpm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready,
    output logic      [COUNT_W-1:0] palette_count,
    output logic                    mono_mode
);

    logic [COUNT_W-1:0] count_reg;
    logic               mono_reg;
    logic               reg_sel;
    logic               wr_en;

    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mono_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_COUNT: count_reg <= pwdata[COUNT_W-1:0];
                REG_MONO:  mono_reg  <= pwdata[0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_COUNT: prdata = DATA_W'(count_reg);
            REG_MONO:  prdata = DATA_W'(mono_reg);
            default:   prdata = '0;
        endcase
    end

    assign palette_count = count_reg;
    assign mono_mode     = mono_reg;

endmodule
`default_nettype wire

/* src/yrpm_ctrl.sv */
// Controller: sequences conversion, palette scan and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module yrpm_ctrl
    import yrpm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_cmd,
    input  wire logic [COUNT_W-1:0] palette_count,
    input  wire logic               mono_mode,
    input  wire dp_stat_t           stat,
    output ctrl_cmd_t               cmd
);

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic [COUNT_W-1:0] limit;
    logic               last_read;

    assign limit     = (palette_count > LIMIT_MAX) ? LIMIT_MAX : palette_count;
    assign last_read = (idx_reg + COUNT_W'(1)) == limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_cmd == CMD_PIXEL)
                    state_next = ST_MUL;
            end
            ST_MUL:
                state_next = ST_SUM;
            ST_SUM:
            begin
                if (mono_mode || limit == '0)
                    state_next = ST_EMIT;
                else
                    state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (last_read)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_SUM:    idx_next = '0;
            ST_SEARCH: idx_next = idx_reg + COUNT_W'(1);
            default:   idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.rd_addr  = idx_reg[IDX_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.capture  = in_valid && in_cmd == CMD_PIXEL;
                cmd.mem_wr   = in_valid && in_cmd == CMD_LOAD;
            end
            ST_MUL:    cmd.mul_en   = 1'b1;
            ST_SUM:    cmd.sum_en   = 1'b1;
            ST_SEARCH: cmd.rd_en    = 1'b1;
            ST_EMIT:   cmd.load_out = stat.out_free;
            default:   ;
        endcase
    end

endmodule
`default_nettype wire

/* src/yrpm_dp.sv */
// Datapath: color conversion, palette memory, distance pipe and output word.
`timescale 1ns / 1ps
`default_nettype none
module yrpm_dp
    import yrpm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctrl_cmd_t         cmd,
    input  wire logic              mono_mode,
    input  wire logic [IDX_W-1:0]  entry_index,
    input  wire logic [CHAN_W-1:0] entry_map_byte,
    input  wire logic [CHAN_W-1:0] entry_red,
    input  wire logic [CHAN_W-1:0] entry_green,
    input  wire logic [CHAN_W-1:0] entry_blue,
    input  wire logic [CHAN_W-1:0] luma,
    input  wire logic [CHAN_W-1:0] chroma_blue,
    input  wire logic [CHAN_W-1:0] chroma_red,
    input  wire logic              out_ready,
    output dp_stat_t               stat,
    output logic                   out_valid,
    output logic      [CHAN_W-1:0] map_byte_out,
    output logic      [CHAN_W-1:0] red_out,
    output logic      [CHAN_W-1:0] green_out,
    output logic      [CHAN_W-1:0] blue_out
);

    // palette word: map | red << 8 | green << 16 | blue << 24
    logic [WORD_W-1:0] mem [PALETTE_DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    logic [CHAN_W-1:0]          y_reg;
    logic signed [CHROMA_W-1:0] cb_reg, cr_reg;
    logic signed [PROD_W-1:0]   r_prod_reg, gcb_prod_reg, gcr_prod_reg, b_prod_reg;
    logic [CHAN_W-1:0]          r_reg, g_reg, b_reg;

    logic signed [SUM_W-1:0]  g_sum;
    logic signed [CONV_W-1:0] y_ext, r_conv, g_conv, b_conv;

    logic              rd_v1_reg, d_v_reg;
    logic [DIST_W-1:0] d_reg, best_d_reg;
    logic [CHAN_W-1:0] d_map_reg, best_map_reg;
    logic [DIST_W-1:0] dist_sum;

    logic              out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0] map_out_reg, red_out_reg, green_out_reg, blue_out_reg;

    function automatic logic [CHAN_W-1:0] clamp_chan(input logic signed [CONV_W-1:0] v);
        logic [CHAN_W-1:0] res;
        if (v < 0)
            res = '0;
        else if (v > $signed(CONV_W'(CHAN_MAX)))
            res = CHAN_MAX;
        else
            res = v[CHAN_W-1:0];
        return res;
    endfunction

    function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        d = (a > b) ? a - b : b - a;
        return d * d;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
            mem[entry_index] <= {entry_blue, entry_green, entry_red, entry_map_byte};
        if (cmd.rd_en)
            rdata_reg <= mem[cmd.rd_addr];
    end

    // conversion: capture, multiply, sum/shift/clamp
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            y_reg  <= luma;
            cb_reg <= $signed({1'b0, chroma_blue} - CHROMA_MID);
            cr_reg <= $signed({1'b0, chroma_red} - CHROMA_MID);
        end
        if (cmd.mul_en)
        begin
            r_prod_reg   <= COEF_R_CR * cr_reg;
            gcb_prod_reg <= COEF_G_CB * cb_reg;
            gcr_prod_reg <= COEF_G_CR * cr_reg;
            b_prod_reg   <= COEF_B_CB * cb_reg;
        end
        if (cmd.sum_en)
        begin
            r_reg <= clamp_chan(r_conv);
            g_reg <= clamp_chan(g_conv);
            b_reg <= clamp_chan(b_conv);
        end
    end

    assign g_sum  = SUM_W'(gcb_prod_reg) + SUM_W'(gcr_prod_reg);
    assign y_ext  = $signed({{(CONV_W-CHAN_W){1'b0}}, y_reg});
    assign r_conv = y_ext + CONV_W'($signed(r_prod_reg[PROD_W-1:FRAC_W]));
    assign g_conv = y_ext - $signed(g_sum[SUM_W-1:FRAC_W]);
    assign b_conv = y_ext + CONV_W'($signed(b_prod_reg[PROD_W-1:FRAC_W]));

    assign dist_sum = DIST_W'(sq_diff(r_reg, rdata_reg[2*CHAN_W-1:CHAN_W]))
                    + DIST_W'(sq_diff(g_reg, rdata_reg[3*CHAN_W-1:2*CHAN_W]))
                    + DIST_W'(sq_diff(b_reg, rdata_reg[4*CHAN_W-1:3*CHAN_W]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v1_reg <= 1'b0;
            d_v_reg   <= 1'b0;
        end
        else
        begin
            rd_v1_reg <= cmd.rd_en;
            d_v_reg   <= rd_v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_v1_reg)
        begin
            d_reg     <= dist_sum;
            d_map_reg <= rdata_reg[CHAN_W-1:0];
        end
        if (cmd.sum_en)
        begin
            best_d_reg   <= DIST_INIT;
            best_map_reg <= '0;
        end
        else if (d_v_reg && d_reg < best_d_reg)
        begin
            best_d_reg   <= d_reg;
            best_map_reg <= d_map_reg;
        end
    end

    assign stat.pipe_busy = rd_v1_reg || d_v_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            map_out_reg   <= mono_mode ? y_reg : best_map_reg;
            red_out_reg   <= mono_mode ? '0 : r_reg;
            green_out_reg <= mono_mode ? '0 : g_reg;
            blue_out_reg  <= mono_mode ? '0 : b_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign map_byte_out = map_out_reg;
    assign red_out      = red_out_reg;
    assign green_out    = green_out_reg;
    assign blue_out     = blue_out_reg;

endmodule
`default_nettype wire

/* dv/testbench.sv */
// Testbench for the YUV to RGB palette matcher: directed table, then random phases checked by a predictor.
`timescale 1ns / 1ps
module testbench;
    import yrpm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int CFG_SETTLE     = 20;
    localparam int END_SETTLE     = 300;
    localparam int NUM_ROWS       = 22;
    localparam int NUM_PHASES     = 14;
    localparam int HOLD_PHASE     = 4;
    localparam int PAUSE_PHASE    = 1;

    localparam int PH_COUNT [NUM_PHASES] = '{3, 16, 1, 8, 64, 0, 5, 256, 511, 32, 12, 2, 20, 9};
    localparam int PH_MONO  [NUM_PHASES] = '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1, 0};
    localparam int PH_MODE  [NUM_PHASES] = '{0, 1, 2, 3, 0, 1, 2, 3, 0, 1, 2, 3, 0, 2};
    localparam int PH_ITEMS [NUM_PHASES] =
        '{100, 100, 100, 100, 80, 60, 80, 40, 30, 100, 100, 100, 60, 100};
    localparam int SEND_IDLE  [4] = '{0, 62, 0, 32};
    localparam int RECV_STALL [4] = '{0, 0, 62, 32};
    localparam logic [7:0] CHAN_LEVELS [5] = '{8'd0, 8'd64, 8'd128, 8'd192, 8'd255};

    typedef struct packed {
        logic [7:0] map_byte, red, green, blue;
    } color_word_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] slot, map_byte, red, green, blue, luma, cb, cr;
    } in_word_t;

    typedef enum logic {
        ROW_WORD,
        ROW_CONFIG
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic               reg_sel;
        logic [DATA_W-1:0]  data;
        in_word_t           w;
        logic               checked;
        color_word_t        exp;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    yrpm_in_if  in_ch ();
    yrpm_out_if out_ch ();

    yuv_to_rgb_palette_matcher DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    color_word_t pal_model [PALETTE_DEPTH];
    bit          pal_written [PALETTE_DEPTH];
    logic [8:0]  cfg_count;
    logic        cfg_mono;
    color_word_t pending_results [$];
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_req;
    int          quiet_cycles = 0;
    stim_row_t   directed_rows [NUM_ROWS];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic [7:0] clamp_chan(input longint v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    function automatic color_word_t predict_pixel(input logic [7:0] y, cb_raw, cr_raw);
        color_word_t o;
        longint      yy, cb, cr;
        int          lim, dr, dg, db;
        logic [31:0] d, best_d;
        o = '0;
        if (cfg_mono)
        begin
            o.map_byte = y;
            return o;
        end
        yy = longint'(y);
        cb = longint'(cb_raw) - longint'(CHROMA_MID);
        cr = longint'(cr_raw) - longint'(CHROMA_MID);
        o.red   = clamp_chan(yy + ((longint'(COEF_R_CR) * cr) >>> FRAC_W));
        o.green = clamp_chan(yy - ((longint'(COEF_G_CB) * cb + longint'(COEF_G_CR) * cr)
                                   >>> FRAC_W));
        o.blue  = clamp_chan(yy + ((longint'(COEF_B_CB) * cb) >>> FRAC_W));
        lim = (cfg_count > LIMIT_MAX) ? int'(LIMIT_MAX) : int'(cfg_count);
        best_d = 32'h7fff_ffff;
        for (int i = 0; i < lim; i++)
        begin
            dr = int'(o.red) - int'(pal_model[i].red);
            dg = int'(o.green) - int'(pal_model[i].green);
            db = int'(o.blue) - int'(pal_model[i].blue);
            d = 32'(dr * dr + dg * dg + db * db);
            // strict less-than: first entry wins a tie
            if (d < best_d)
            begin
                best_d = d;
                o.map_byte = pal_model[i].map_byte;
            end
        end
        return o;
    endfunction

    function automatic stim_row_t mk_pixel(input logic [7:0] y, cb, cr,
                                           input bit typed = 1'b0,
                                           input color_word_t e = '0);
        stim_row_t r;
        r = '0;
        r.kind = ROW_WORD;
        r.w.cmd = CMD_PIXEL;
        r.w.luma = y;
        r.w.cb = cb;
        r.w.cr = cr;
        r.checked = typed;
        r.exp = e;
        return r;
    endfunction

    function automatic stim_row_t mk_load(input logic [7:0] slot, map_byte, rr, gg, bb);
        stim_row_t r;
        r = '0;
        r.kind = ROW_WORD;
        r.w.cmd = CMD_LOAD;
        r.w.slot = slot;
        r.w.map_byte = map_byte;
        r.w.red = rr;
        r.w.green = gg;
        r.w.blue = bb;
        return r;
    endfunction

    function automatic stim_row_t mk_cfg(input logic reg_sel, input logic [DATA_W-1:0] data);
        stim_row_t r;
        r = '0;
        r.kind = ROW_CONFIG;
        r.reg_sel = reg_sel;
        r.data = data;
        return r;
    endfunction

    function automatic logic [7:0] rand_chan();
        if ($urandom_range(3) == 0)
            return CHAN_LEVELS[$urandom_range(4)];
        return 8'($urandom_range(255));
    endfunction

    function automatic in_word_t rand_word(input logic cmd, input logic [7:0] slot);
        in_word_t w;
        w.cmd = cmd;
        w.slot = slot;
        w.map_byte = 8'($urandom());
        w.red = rand_chan();
        w.green = rand_chan();
        w.blue = rand_chan();
        w.luma = rand_chan();
        w.cb = rand_chan();
        w.cr = rand_chan();
        return w;
    endfunction

    task automatic send_word(input in_word_t w, input bit typed, input color_word_t typed_exp);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.cmd = w.cmd;
        in_ch.entry_index = w.slot;
        in_ch.entry_map_byte = w.map_byte;
        in_ch.entry_red = w.red;
        in_ch.entry_green = w.green;
        in_ch.entry_blue = w.blue;
        in_ch.luma = w.luma;
        in_ch.chroma_blue = w.cb;
        in_ch.chroma_red = w.cr;
        in_ch.valid = 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        if (w.cmd == CMD_LOAD)
        begin
            pal_model[w.slot] = '{w.map_byte, w.red, w.green, w.blue};
            pal_written[w.slot] = 1'b1;
        end
        else
            pending_results.push_back(typed ? typed_exp : predict_pixel(w.luma, w.cb, w.cr));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic reg_sel, input logic [DATA_W-1:0] value);
        wait_drained();
        // loads leave no result behind, give them time to land
        repeat (CFG_SETTLE) @(posedge clk);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = ADDR_W'({reg_sel, 2'b00});
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (reg_sel == REG_COUNT)
            cfg_count = value[8:0];
        else
            cfg_mono = value[0];
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // receiver: random stalls plus an on-demand long hold
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_ch.ready = 1'b0;
                hold_left--;
            end
            else
                out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        color_word_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.map_byte_out, out_ch.red_out, out_ch.green_out, out_ch.blue_out};
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected word %h", got));
            else
            begin
                want = pending_results.pop_front();
                if (got.map_byte !== want.map_byte)
                    report_mismatch($sformatf("map_byte got %h want %h", got.map_byte,
                                              want.map_byte));
                if (got.red !== want.red)
                    report_mismatch($sformatf("red got %h want %h", got.red, want.red));
                if (got.green !== want.green)
                    report_mismatch($sformatf("green got %h want %h", got.green, want.green));
                if (got.blue !== want.blue)
                    report_mismatch($sformatf("blue got %h want %h", got.blue, want.blue));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("yuv_to_rgb_palette_matcher test failed");
            $finish;
        end
    end

    initial
    begin
        int         lim;
        logic [7:0] slot;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_LOAD;
        in_ch.entry_index = '0;
        in_ch.entry_map_byte = '0;
        in_ch.entry_red = '0;
        in_ch.entry_green = '0;
        in_ch.entry_blue = '0;
        in_ch.luma = '0;
        in_ch.chroma_blue = '0;
        in_ch.chroma_red = '0;
        cfg_count = '0;
        cfg_mono = 1'b0;
        mismatch_count = 0;
        hold_req = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;

        directed_rows = '{
            // empty palette after reset: map byte 0
            mk_pixel(8'd0, 8'd128, 8'd128, 1'b1, 32'h00_00_00_00),
            mk_pixel(8'd255, 8'd128, 8'd128, 1'b1, 32'h00_ff_ff_ff),
            mk_pixel(8'd0, 8'd0, 8'd0),
            mk_pixel(8'd255, 8'd255, 8'd255),
            mk_pixel(8'd255, 8'd0, 8'd255),
            mk_pixel(8'd0, 8'd255, 8'd0),
            mk_load(8'd0, 8'ha5, 8'd0, 8'd0, 8'd0),
            mk_load(8'd1, 8'h5a, 8'd255, 8'd255, 8'd255),
            mk_load(8'd2, 8'h11, 8'd0, 8'd0, 8'd0),
            mk_load(8'd3, 8'hff, 8'd255, 8'd0, 8'd255),
            mk_load(8'd255, 8'h00, 8'd255, 8'd255, 8'd255),
            mk_cfg(REG_COUNT, 32'd4),
            // black ties entries 0 and 2, first wins
            mk_pixel(8'd0, 8'd128, 8'd128, 1'b1, 32'ha5_00_00_00),
            mk_pixel(8'd255, 8'd128, 8'd128, 1'b1, 32'h5a_ff_ff_ff),
            mk_pixel(8'd128, 8'd200, 8'd60),
            mk_pixel(8'd200, 8'd40, 8'd220),
            mk_cfg(REG_MONO, 32'd1),
            mk_pixel(8'hc3, 8'd17, 8'd240, 1'b1, 32'hc3_00_00_00),
            mk_pixel(8'hff, 8'd0, 8'd255, 1'b1, 32'hff_00_00_00),
            mk_cfg(REG_MONO, 32'd0),
            mk_cfg(REG_COUNT, 32'd0),
            mk_pixel(8'd77, 8'd128, 8'd128, 1'b1, 32'h00_4d_4d_4d)
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CONFIG)
                cfg_write(directed_rows[i].reg_sel, directed_rows[i].data);
            else
                send_word(directed_rows[i].w, directed_rows[i].checked, directed_rows[i].exp);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            send_idle_pct = SEND_IDLE[PH_MODE[p]];
            recv_stall_pct = RECV_STALL[PH_MODE[p]];
            cfg_write(REG_COUNT, ($urandom() & ~32'h1ff) | PH_COUNT[p]);
            cfg_write(REG_MONO, ($urandom() & ~32'h1) | PH_MONO[p]);
            lim = (PH_COUNT[p] > PALETTE_DEPTH) ? PALETTE_DEPTH : PH_COUNT[p];
            // every searched entry must hold a loaded value
            for (int i = 0; i < lim; i++)
                if (!pal_written[i])
                    send_word(rand_word(CMD_LOAD, 8'(i)), 1'b0, '0);
            for (int n = 0; n < PH_ITEMS[p]; n++)
            begin
                if (p == HOLD_PHASE && n == 20)
                    hold_req = 1'b1;
                if (p == PAUSE_PHASE && n == 50)
                    wait_drained();
                if ($urandom_range(9) < 3)
                begin
                    if ($urandom_range(9) < 7 && lim > 0)
                        slot = 8'($urandom_range(lim - 1));
                    else
                        slot = 8'($urandom_range(255));
                    send_word(rand_word(CMD_LOAD, slot), 1'b0, '0);
                end
                else
                    send_word(rand_word(CMD_PIXEL, 8'($urandom())), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (END_SETTLE) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("yuv_to_rgb_palette_matcher test passed");
        else
            $display("yuv_to_rgb_palette_matcher test failed");
        $finish;
    end

endmodule
